/* rtl/mfp_pkg.sv */
// mfp_pkg: shared constants, codes and struct types of the magnetometer frame parser
// no dependencies; imported by every module in rtl/

package mfp_pkg;

  // frame layout
  localparam int unsigned PAYLOAD_BYTES = 10;
  localparam int unsigned AXIS_BYTES    = 9;
  localparam int unsigned PAY_CNT_W     = $clog2(PAYLOAD_BYTES);

  localparam logic [7:0] HDR_BYTE0 = 8'hFF;
  localparam logic [7:0] HDR_BYTE1 = 8'h7E;
  localparam logic [7:0] HDR_BYTE2 = 8'h01;
  localparam logic [7:0] HDR_BYTE3 = 8'h09;

  // datapath widths
  localparam int unsigned FS_W    = 20;
  localparam logic [FS_W-1:0] FS_RESET = 20'd100000;
  localparam int unsigned RAW_W   = 24;
  localparam int unsigned SCL_W   = 29;
  localparam int unsigned SCL_LSB = 15;
  localparam int unsigned SUM_W   = 48;
  localparam int unsigned ROOT_W  = SUM_W / 2;
  localparam int unsigned MUL_W   = RAW_W + 1;
  localparam int unsigned PROD_W  = 2 * MUL_W;
  localparam int unsigned OUT_W   = 192;

  // where a product of the shared multiplier goes
  typedef enum logic [2:0] {
    DST_SUM,
    DST_XS,
    DST_YS,
    DST_ZS,
    DST_MAG
  } mfp_dst_e;

  typedef struct packed {
    logic                    valid;
    mfp_dst_e                dst;
    logic signed [MUL_W-1:0] a;
    logic signed [MUL_W-1:0] b;
  } mfp_mul_op_t;

  typedef struct packed {
    logic     valid;
    mfp_dst_e dst;
  } mfp_mul_tag_t;

  // completed frame, valid for the cycle of its last payload byte
  typedef struct packed {
    logic                    done;
    logic signed [RAW_W-1:0] x;
    logic signed [RAW_W-1:0] y;
    logic signed [RAW_W-1:0] z;
  } mfp_frame_t;

endpackage

/* rtl/magnetometer_frame_parser.sv */
// magnetometer_frame_parser: top level, sequencer around a shared multiplier and root unit
// depends on mfp_pkg, mfp_parser, mfp_mul, mfp_isqrt
//
//  channel   dir  handshake                    payload
//  s_axis    in   s_axis_tvalid/s_axis_tready  rx_byte
//  m_axis    out  m_axis_tvalid/m_axis_tready  raw axes, scaled axes, field magnitude
//  cfg       in   cfg_valid_i/cfg_ready_o      full_scale
//
// a byte that does not end a frame is taken while the block is idle
// the last payload byte starts the busy run: three squares and three axis
// scalings on the shared multiplier, a wait on the root, one more
// multiply for the magnitude, its write-back and the output register load
// s_axis_tready is low while busy, also while a finished result waits for
// the output register to be free; once loaded, the result waits there
// and the block takes bytes until the next frame completes
// reset clears the header hunt and full_scale to 100000

module magnetometer_frame_parser import mfp_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  input  logic [7:0]       s_axis_tdata,   // [7:0] rx_byte
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  output logic [OUT_W-1:0] m_axis_tdata,   // [23:0] x_raw, [47:24] y_raw, [71:48] z_raw,
                                           // [100:72] x_scaled, [129:101] y_scaled,
                                           // [158:130] z_scaled, [187:159] field_magnitude,
                                           // [191:188] zero
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  logic [FS_W-1:0]  cfg_data_i      // full_scale
);

  localparam logic [2:0] SQ_IDLE   = 3'd0;
  localparam logic [2:0] SQ_SQUARE = 3'd1;
  localparam logic [2:0] SQ_SCALE  = 3'd2;
  localparam logic [2:0] SQ_ROOT   = 3'd3;
  localparam logic [2:0] SQ_MAG    = 3'd4;
  localparam logic [2:0] SQ_MAGWB  = 3'd5;
  localparam logic [2:0] SQ_DONE   = 3'd6;

  localparam logic [1:0] LAST_AXIS  = 2'd2;
  localparam logic [1:0] ROOT_AXIS  = 2'd1;

  logic [2:0]               state_q;
  logic [1:0]               idx_q;
  logic [FS_W-1:0]          fs_q;
  logic signed [RAW_W-1:0]  ax_q [3];
  logic [SUM_W-1:0]         sum_q;
  logic [SCL_W-1:0]         sc_q [3];
  logic [SCL_W-1:0]         mag_q;
  logic [OUT_W-1:0]         m_data_q;
  logic                     m_valid_q;

  logic                     byte_valid;
  mfp_frame_t               frame;
  mfp_mul_op_t              mul_op;
  logic signed [PROD_W-1:0] prod;
  mfp_mul_tag_t             mul_tag;
  logic                     isq_start;
  logic                     isq_busy;
  logic                     isq_done;
  logic [ROOT_W-1:0]        isq_root;
  logic signed [MUL_W-1:0]  ax_ext;
  logic                     out_load;
  logic [SCL_W-1:0]         prod_scl;

  assign s_axis_tready = (state_q == SQ_IDLE);
  assign byte_valid    = s_axis_tvalid && s_axis_tready;
  assign cfg_ready_o   = 1'b1;

  mfp_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .byte_valid_i(byte_valid),
    .byte_i      (s_axis_tdata),
    .frame_o     (frame)
  );

  // operand selection for the shared multiplier
  assign ax_ext = {ax_q[idx_q][RAW_W-1], ax_q[idx_q]};

  always_comb begin
    mul_op.valid = 1'b0;
    mul_op.dst   = DST_SUM;
    mul_op.a     = ax_ext;
    mul_op.b     = MUL_W'(signed'({1'b0, fs_q}));
    unique case (state_q)
      SQ_SQUARE: begin
        mul_op.valid = 1'b1;
        mul_op.b     = ax_ext;
      end
      SQ_SCALE: begin
        mul_op.valid = 1'b1;
        case (idx_q)
          2'd0:    mul_op.dst = DST_XS;
          2'd1:    mul_op.dst = DST_YS;
          default: mul_op.dst = DST_ZS;
        endcase
      end
      SQ_MAG: begin
        mul_op.valid = 1'b1;
        mul_op.dst   = DST_MAG;
        mul_op.a     = MUL_W'(signed'({1'b0, isq_root}));
      end
      default: mul_op.valid = 1'b0;
    endcase
  end

  mfp_mul u_mul (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .op_i  (mul_op),
    .prod_o(prod),
    .tag_o (mul_tag)
  );

  // the root starts once the last square has landed in the sum
  assign isq_start = (state_q == SQ_SCALE) && (idx_q == ROOT_AXIS);

  mfp_isqrt u_isqrt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(isq_start),
    .rad_i  (sum_q),
    .busy_o (isq_busy),
    .done_o (isq_done),
    .root_o (isq_root)
  );

  // product write-back, floor shift by bit selection
  assign prod_scl = prod[SCL_LSB +: SCL_W];

  always_ff @(posedge clk_i) begin
    if (frame.done && (state_q == SQ_IDLE)) begin
      sum_q <= '0;
      ax_q[0] <= frame.x;
      ax_q[1] <= frame.y;
      ax_q[2] <= frame.z;
    end else if (mul_tag.valid) begin
      case (mul_tag.dst)
        DST_SUM: sum_q    <= sum_q + prod[SUM_W-1:0];
        DST_XS:  sc_q[0]  <= prod_scl;
        DST_YS:  sc_q[1]  <= prod_scl;
        DST_ZS:  sc_q[2]  <= prod_scl;
        DST_MAG: mag_q    <= prod_scl;
        default: sum_q    <= sum_q;
      endcase
    end
  end

  // configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fs_q <= FS_RESET;
    end else if (cfg_valid_i) begin
      fs_q <= cfg_data_i;
    end
  end

  assign out_load = (state_q == SQ_DONE) && (!m_valid_q || m_axis_tready);

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SQ_IDLE;
      idx_q   <= '0;
    end else begin
      unique case (state_q)
        SQ_IDLE: begin
          if (frame.done) begin
            state_q <= SQ_SQUARE;
            idx_q   <= '0;
          end
        end
        SQ_SQUARE: begin
          if (idx_q == LAST_AXIS) begin
            state_q <= SQ_SCALE;
            idx_q   <= '0;
          end else begin
            idx_q <= idx_q + 1'b1;
          end
        end
        SQ_SCALE: begin
          if (idx_q == LAST_AXIS) begin
            state_q <= SQ_ROOT;
            idx_q   <= '0;
          end else begin
            idx_q <= idx_q + 1'b1;
          end
        end
        SQ_ROOT: begin
          if (isq_done) begin
            state_q <= SQ_MAG;
          end
        end
        SQ_MAG:   state_q <= SQ_MAGWB;
        SQ_MAGWB: state_q <= SQ_DONE;
        SQ_DONE: begin
          if (out_load) begin
            state_q <= SQ_IDLE;
          end
        end
        default: state_q <= SQ_IDLE;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (out_load) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      m_data_q <= {4'b0000, mag_q, sc_q[2], sc_q[1], sc_q[0], ax_q[2], ax_q[1], ax_q[0]};
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

  a_sum_from_squares: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mul_tag.valid && (mul_tag.dst == DST_SUM)) |-> ($past(state_q) == SQ_SQUARE))
    else $error("square product landed outside the square phase");

  a_root_start_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    isq_start |-> !isq_busy)
    else $error("root started while the previous root still runs");

  a_mag_after_root: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == SQ_MAG) |-> $past(isq_done))
    else $error("magnitude multiply issued before the root was ready");

endmodule

/* rtl/mfp_parser.sv */
// mfp_parser: header hunt, skip byte and payload gathering into three raw axes
// depends on mfp_pkg

module mfp_parser import mfp_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       byte_valid_i,
  input  logic [7:0] byte_i,
  output mfp_frame_t frame_o
);

  localparam logic [2:0] PH_HDR0   = 3'd0;
  localparam logic [2:0] PH_HDR1   = 3'd1;
  localparam logic [2:0] PH_HDR2   = 3'd2;
  localparam logic [2:0] PH_HDR3   = 3'd3;
  localparam logic [2:0] PH_SKIP   = 3'd4;
  localparam logic [2:0] PH_GATHER = 3'd5;

  localparam logic [PAY_CNT_W-1:0] LAST_CNT = PAY_CNT_W'(PAYLOAD_BYTES - 1);

  logic [2:0]           phase_q, phase_d;
  logic [PAY_CNT_W-1:0] count_q, count_d;
  logic [7:0]           store_q [AXIS_BYTES];
  logic [7:0]           cur     [AXIS_BYTES];
  logic                 gather;
  logic                 last;

  assign gather = byte_valid_i && (phase_q == PH_GATHER);
  assign last   = gather && (count_q == LAST_CNT);

  // phase sequencer
  always_comb begin
    phase_d = phase_q;
    count_d = count_q;
    if (byte_valid_i) begin
      unique case (phase_q)
        PH_HDR0: phase_d = (byte_i == HDR_BYTE0) ? PH_HDR1 : PH_HDR0;
        PH_HDR1: phase_d = (byte_i == HDR_BYTE1) ? PH_HDR2 : PH_HDR0;
        PH_HDR2: phase_d = (byte_i == HDR_BYTE2) ? PH_HDR3 : PH_HDR0;
        PH_HDR3: phase_d = (byte_i == HDR_BYTE3) ? PH_SKIP : PH_HDR0;
        PH_SKIP: begin
          phase_d = PH_GATHER;
          count_d = '0;
        end
        PH_GATHER: begin
          if (count_q == LAST_CNT) begin
            phase_d = PH_HDR0;
            count_d = '0;
          end else begin
            count_d = count_q + 1'b1;
          end
        end
        default: phase_d = PH_HDR0;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HDR0;
      count_q <= '0;
    end else begin
      phase_q <= phase_d;
      count_q <= count_d;
    end
  end

  // payload bytes; the byte arriving now is folded in for its own index, the last (padding) byte is not stored
  for (genvar i = 0; i < AXIS_BYTES; i++) begin : g_store
    always_ff @(posedge clk_i) begin
      if (gather && (count_q == PAY_CNT_W'(i))) begin
        store_q[i] <= byte_i;
      end
    end
    assign cur[i] = (count_q == PAY_CNT_W'(i)) ? byte_i : store_q[i];
  end

  // little-endian axes
  assign frame_o.done = last;
  assign frame_o.x    = {cur[2], cur[1], cur[0]};
  assign frame_o.y    = {cur[5], cur[4], cur[3]};
  assign frame_o.z    = {cur[8], cur[7], cur[6]};

endmodule

/* rtl/mfp_mul.sv */
// mfp_mul: shared signed multiplier with registered product and destination tag
// depends on mfp_pkg

module mfp_mul import mfp_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  mfp_mul_op_t              op_i,
  output logic signed [PROD_W-1:0] prod_o,
  output mfp_mul_tag_t             tag_o
);

  logic signed [PROD_W-1:0] prod_q;
  mfp_mul_tag_t             tag_q;

  // product register
  always_ff @(posedge clk_i) begin
    if (op_i.valid) begin
      prod_q <= op_i.a * op_i.b;
    end
  end

  // tag is registered alongside the product
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag_q <= '{valid: 1'b0, dst: DST_SUM};
    end else begin
      tag_q.valid <= op_i.valid;
      tag_q.dst   <= op_i.dst;
    end
  end

  assign prod_o = prod_q;
  assign tag_o  = tag_q;

endmodule

/* rtl/mfp_isqrt.sv */
// mfp_isqrt: iterative floor square root, one result bit per cycle
// depends on mfp_pkg

module mfp_isqrt import mfp_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [SUM_W-1:0]  rad_i,
  output logic              busy_o,
  output logic              done_o,
  output logic [ROOT_W-1:0] root_o
);

  localparam int unsigned REM_W = ROOT_W + 2;
  localparam int unsigned CNT_W = $clog2(ROOT_W);

  logic [SUM_W-1:0]  rad_q;
  logic [REM_W-1:0]  rem_q, rem_d;
  logic [ROOT_W-1:0] root_q, root_d;
  logic [CNT_W-1:0]  cnt_q;
  logic              busy_q;
  logic              done_q;
  logic [REM_W+1:0]  rem_sh;
  logic [REM_W+1:0]  trial;
  logic              ge;

  // one restoring step: bring down two bits, try 4*root+1
  always_comb begin
    rem_sh = {rem_q, rad_q[SUM_W-1 -: 2]};
    trial  = {2'b00, root_q, 2'b01};
    ge     = rem_sh >= trial;
    rem_d  = ge ? REM_W'(rem_sh - trial) : REM_W'(rem_sh);
    root_d = {root_q[ROOT_W-2:0], ge};
  end

  // datapath
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rad_q  <= rad_i;
      rem_q  <= '0;
      root_q <= '0;
    end else if (busy_q) begin
      rad_q  <= rad_q << 2;
      rem_q  <= rem_d;
      root_q <= root_d;
    end
  end

  // iteration count and status
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else if (start_i) begin
      cnt_q  <= CNT_W'(ROOT_W - 1);
      busy_q <= 1'b1;
      done_q <= 1'b0;
    end else if (busy_q) begin
      cnt_q <= cnt_q - 1'b1;
      if (cnt_q == '0) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  assign busy_o = busy_q;
  assign done_o = done_q;
  assign root_o = root_q;

  // done is a single pulse right after the last step
  a_done_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> !busy_q && $past(busy_q))
    else $error("root done without a finished iteration run");

endmodule

/* sim/mfp_reading_check.sv */
// mfp_reading_check: watches the byte, reading and full_scale channels of the frame parser,
// predicts each reading from the accepted bytes and compares it field by field
// depends on mfp_pkg
`timescale 1ns / 100ps

module mfp_reading_check import mfp_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             s_axis_tvalid,
  input  logic             s_axis_tready,
  input  logic [7:0]       s_axis_tdata,   // [7:0] rx_byte
  input  logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  input  logic [OUT_W-1:0] m_axis_tdata,   // [23:0] x_raw, [47:24] y_raw, [71:48] z_raw,
                                           // [100:72] x_scaled, [129:101] y_scaled,
                                           // [158:130] z_scaled, [187:159] field_magnitude
  input  logic             cfg_valid_i,
  input  logic             cfg_ready_o,
  input  logic [FS_W-1:0]  cfg_data_i,     // full_scale
  output int               fail_count_o,
  output int               checked_o,
  output int               pending_o
);

  typedef enum logic [2:0] {
    HUNT_FF,
    HUNT_7E,
    HUNT_01,
    HUNT_09,
    SKIP_BYTE,
    GATHER
  } hunt_e;

  typedef struct {
    logic [RAW_W-1:0] x_raw;
    logic [RAW_W-1:0] y_raw;
    logic [RAW_W-1:0] z_raw;
    logic [SCL_W-1:0] x_scaled;
    logic [SCL_W-1:0] y_scaled;
    logic [SCL_W-1:0] z_scaled;
    logic [SCL_W-1:0] magnitude;
  } reading_t;

  hunt_e           phase;
  logic [3:0]      pay_cnt;
  logic [7:0]      pay_bytes [AXIS_BYTES];
  logic [FS_W-1:0] scale_reg;
  reading_t        readings_q [$];

  // floor(raw * full_scale / 2^15), arithmetic shift floors negative values
  function automatic longint scale_reading(longint raw, longint fs);
    return (raw * fs) >>> SCL_LSB;
  endfunction

  // floor square root, the root of a 48-bit sum fits 24 bits
  function automatic longint floor_root(longint n);
    longint r;
    longint cand;
    r = 0;
    for (int i = ROOT_W - 1; i >= 0; i--) begin
      cand = r | (64'sd1 << i);
      if (cand * cand <= n) r = cand;
    end
    return r;
  endfunction

  // advance the header hunt by one byte, queue a reading on the last payload byte
  task automatic take_byte(logic [7:0] b);
    longint   ax [3];
    longint   sc [3];
    longint   sum;
    longint   mag;
    reading_t rd;
    case (phase)
      HUNT_FF: phase = (b == HDR_BYTE0) ? HUNT_7E : HUNT_FF;
      HUNT_7E: phase = (b == HDR_BYTE1) ? HUNT_01 : HUNT_FF;
      HUNT_01: phase = (b == HDR_BYTE2) ? HUNT_09 : HUNT_FF;
      HUNT_09: phase = (b == HDR_BYTE3) ? SKIP_BYTE : HUNT_FF;
      SKIP_BYTE: begin
        phase   = GATHER;
        pay_cnt = '0;
      end
      GATHER: begin
        if (pay_cnt < AXIS_BYTES) pay_bytes[pay_cnt] = b;
        if (pay_cnt + 1 < PAYLOAD_BYTES) begin
          pay_cnt = pay_cnt + 1'b1;
        end else begin
          phase   = HUNT_FF;
          pay_cnt = '0;
          sum     = 0;
          for (int k = 0; k < 3; k++) begin
            ax[k] = $signed({pay_bytes[3*k+2], pay_bytes[3*k+1], pay_bytes[3*k]});
            sc[k] = scale_reading(ax[k], longint'(scale_reg));
            sum   = sum + ax[k] * ax[k];
          end
          mag          = (floor_root(sum) * longint'(scale_reg)) >>> SCL_LSB;
          rd.x_raw     = ax[0][RAW_W-1:0];
          rd.y_raw     = ax[1][RAW_W-1:0];
          rd.z_raw     = ax[2][RAW_W-1:0];
          rd.x_scaled  = sc[0][SCL_W-1:0];
          rd.y_scaled  = sc[1][SCL_W-1:0];
          rd.z_scaled  = sc[2][SCL_W-1:0];
          rd.magnitude = mag[SCL_W-1:0];
          readings_q.push_back(rd);
        end
      end
      default: phase = HUNT_FF;
    endcase
  endtask

  task automatic check_field(string name, logic [SCL_W-1:0] want, logic [SCL_W-1:0] got);
    if (want !== got) begin
      fail_count_o++;
      $display("%0t: %s mismatch, expected %h actual %h", $time, name, want, got);
    end
  endtask

  // per-edge bookkeeping: register write, reading compare, then byte prediction
  always @(posedge clk_i or negedge rst_ni) begin
    reading_t want;
    if (!rst_ni) begin
      phase        = HUNT_FF;
      pay_cnt      = '0;
      scale_reg    = FS_RESET;
      readings_q.delete();
      fail_count_o = 0;
      checked_o    = 0;
      pending_o    = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) scale_reg = cfg_data_i;

      if (m_axis_tvalid && m_axis_tready) begin
        if (readings_q.size() == 0) begin
          fail_count_o++;
          $display("%0t: reading with none expected, expected nothing actual %h",
                   $time, m_axis_tdata);
        end else begin
          want = readings_q.pop_front();
          check_field("x_raw", want.x_raw, m_axis_tdata[23:0]);
          check_field("y_raw", want.y_raw, m_axis_tdata[47:24]);
          check_field("z_raw", want.z_raw, m_axis_tdata[71:48]);
          check_field("x_scaled", want.x_scaled, m_axis_tdata[100:72]);
          check_field("y_scaled", want.y_scaled, m_axis_tdata[129:101]);
          check_field("z_scaled", want.z_scaled, m_axis_tdata[158:130]);
          check_field("field_magnitude", want.magnitude, m_axis_tdata[187:159]);
          checked_o++;
        end
      end

      if (s_axis_tvalid && s_axis_tready) take_byte(s_axis_tdata);
      pending_o = readings_q.size();
    end
  end

endmodule

/* sim/testbench.sv */
// testbench: drives bytes, full_scale writes and output stalls into the frame parser
// depends on mfp_pkg, magnetometer_frame_parser and mfp_reading_check
`timescale 1ns / 100ps

module testbench import mfp_pkg::*; ();

  localparam int HALF_PERIOD = 6;
  localparam int SETTLE      = 40;
  localparam int HOLD_CYCLES = 400;

  logic             clk_i         = 1'b0;
  logic             rst_ni        = 1'b0;
  logic             s_axis_tvalid = 1'b0;
  logic             s_axis_tready;
  logic [7:0]       s_axis_tdata  = '0;
  logic             m_axis_tvalid;
  logic             m_axis_tready = 1'b0;
  logic [OUT_W-1:0] m_axis_tdata;
  logic             cfg_valid_i   = 1'b0;
  logic             cfg_ready_o;
  logic [FS_W-1:0]  cfg_data_i    = '0;

  int   fail_count;
  int   checked;
  int   pending;
  int   send_idle_pct = 0;
  int   recv_idle_pct = 0;
  int   bytes_sent    = 0;
  int   fs_writes     = 0;
  int   hold_reqs     = 0;
  int   holds_done    = 0;
  logic byte_taken;
  logic cfg_taken;

  always #(HALF_PERIOD) clk_i = ~clk_i;

  magnetometer_frame_parser DUT (
    .clk_i,
    .rst_ni,
    .s_axis_tvalid,
    .s_axis_tready,
    .s_axis_tdata,
    .m_axis_tvalid,
    .m_axis_tready,
    .m_axis_tdata,
    .cfg_valid_i,
    .cfg_ready_o,
    .cfg_data_i
  );

  mfp_reading_check reading_check (
    .clk_i,
    .rst_ni,
    .s_axis_tvalid,
    .s_axis_tready,
    .s_axis_tdata,
    .m_axis_tvalid,
    .m_axis_tready,
    .m_axis_tdata,
    .cfg_valid_i,
    .cfg_ready_o,
    .cfg_data_i,
    .fail_count_o (fail_count),
    .checked_o    (checked),
    .pending_o    (pending)
  );

  // completed requests, seen by the stimulus at the following falling edge
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_taken <= 1'b0;
      cfg_taken  <= 1'b0;
    end else begin
      byte_taken <= s_axis_tvalid && s_axis_tready;
      cfg_taken  <= cfg_valid_i && cfg_ready_o;
    end
  end

  // output side: random stalls, or a long hold-off on request
  initial begin
    forever begin
      @(negedge clk_i);
      if (hold_reqs != holds_done) begin
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk_i);
        holds_done++;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // one byte request, entered and left at a falling edge
  task automatic send_byte(logic [7:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    do @(negedge clk_i); while (!byte_taken);
    bytes_sent++;
  endtask

  task automatic send_frame(logic [23:0] x, logic [23:0] y, logic [23:0] z,
                            logic [7:0] skip, logic [7:0] pad);
    logic [71:0] axes;
    axes = {z, y, x};
    send_byte(HDR_BYTE0);
    send_byte(HDR_BYTE1);
    send_byte(HDR_BYTE2);
    send_byte(HDR_BYTE3);
    send_byte(skip);
    for (int i = 0; i < AXIS_BYTES; i++) send_byte(axes[8*i +: 8]);
    send_byte(pad);
  endtask

  function automatic logic [23:0] pick_axis();
    case ($urandom_range(9))
      0:       return 24'h7FFFFF;
      1:       return 24'h800000;
      2:       return 24'h000000;
      3:       return 24'hFFFFFF;
      4:       return 24'($urandom_range(255));
      default: return 24'($urandom);
    endcase
  endfunction

  // mostly whole frames with random content, some broken headers and line noise
  task automatic random_traffic(int n_bytes);
    int         stop;
    int         pick;
    int         depth;
    logic [7:0] hdr [4];
    logic [7:0] wrong;
    hdr  = '{HDR_BYTE0, HDR_BYTE1, HDR_BYTE2, HDR_BYTE3};
    stop = bytes_sent + n_bytes;
    while (bytes_sent < stop) begin
      pick = $urandom_range(99);
      if (pick < 75) begin
        send_frame(pick_axis(), pick_axis(), pick_axis(), 8'($urandom), 8'($urandom));
      end else if (pick < 90) begin
        depth = $urandom_range(3, 1);
        for (int i = 0; i < depth; i++) send_byte(hdr[i]);
        wrong = 8'($urandom);
        if (wrong == hdr[depth]) wrong = wrong ^ 8'h80;
        send_byte(wrong);
      end else begin
        repeat ($urandom_range(4, 1)) send_byte(8'($urandom));
      end
    end
  endtask

  // wait until every reading is out and the block has settled
  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (SETTLE) @(negedge clk_i);
  endtask

  task automatic write_full_scale(logic [FS_W-1:0] v);
    wait_idle();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= v;
    do @(negedge clk_i); while (!cfg_taken);
    cfg_valid_i <= 1'b0;
    fs_writes++;
  endtask

  // stimulus and verdict
  initial begin
    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed: header restart without recheck, late mismatch, all-negative frame
    send_idle_pct = 20;
    recv_idle_pct = 49;
    send_byte(HDR_BYTE0);
    send_byte(HDR_BYTE0);
    send_byte(HDR_BYTE1);
    send_byte(HDR_BYTE2);
    send_byte(HDR_BYTE3);
    send_byte(8'h00);
    send_byte(HDR_BYTE0);
    send_byte(HDR_BYTE1);
    send_byte(HDR_BYTE2);
    send_byte(8'h00);
    send_frame(24'h800000, 24'h800000, 24'h800000, 8'hFF, 8'h00);

    // largest full_scale, sender idles less than receiver
    write_full_scale({FS_W{1'b1}});
    random_traffic(150);

    // zero full_scale, idling swapped
    send_idle_pct = 49;
    recv_idle_pct = 20;
    write_full_scale('0);
    random_traffic(150);

    // random full_scale, no idling, long output hold-off first
    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_full_scale(FS_W'($urandom_range((1 << FS_W) - 2, 1)));
    @(posedge clk_i);
    hold_reqs++;
    @(negedge clk_i);
    repeat (3) send_frame(pick_axis(), pick_axis(), pick_axis(), 8'h5A, 8'hA5);
    wait (holds_done == hold_reqs);
    @(negedge clk_i);
    random_traffic(140);

    wait_idle();
    $display("sent %0d bytes, checked %0d readings over %0d full_scale writes",
             bytes_sent, checked, fs_writes);
    $display("covered header restarts, axis extremes, idle mixes and a long output stall");
    if (fail_count == 0) begin
      $display("magnetometer_frame_parser test passed");
    end else begin
      $display("magnetometer_frame_parser test failed");
    end
    $finish;
  end

  // run limit
  initial begin
    #(3_000_000);
    $display("magnetometer_frame_parser test failed");
    $finish;
  end

endmodule
